FILE: sv/crc_eng_pkg.sv
// ----------------------------------------------------------------------------
// crc_eng_pkg: shared types, constants and helpers of the crc engine
// Holds the register codes, reset values and the bytewise crc update.
// ----------------------------------------------------------------------------
`default_nettype none

package crc_eng_pkg;

   // datapath and width limits
   localparam int CRC_WORD_WIDTH  = 32;
   localparam int CRC_MAX_WIDTH   = 32;
   localparam int CRC_MIN_WIDTH   = 4;
   localparam int CRC_WIDTH_LIMIT = (CRC_MAX_WIDTH < CRC_WORD_WIDTH) ?
                                    CRC_MAX_WIDTH : CRC_WORD_WIDTH;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int WIDTH_REG_BITS  = 6;
   localparam int SHIFT_BITS      = 5;

   typedef logic [CRC_WORD_WIDTH-1:0]  crc_word_type;
   typedef logic [WIDTH_REG_BITS-1:0]  crc_width_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   // register indexes
   localparam csr_index_type CSR_CRC_WIDTH     = 3'd0;
   localparam csr_index_type CSR_POLYNOMIAL    = 3'd1;
   localparam csr_index_type CSR_INITIAL_VALUE = 3'd2;
   localparam csr_index_type CSR_REFLECT_BITS  = 3'd3;
   localparam csr_index_type CSR_FINAL_XOR     = 3'd4;

   // reset values (crc-32 with reflected input and output)
   localparam crc_width_type RST_CRC_WIDTH     = 6'd32;
   localparam crc_word_type  RST_POLYNOMIAL    = 32'h04C1_1DB7;
   localparam crc_word_type  RST_INITIAL_VALUE = 32'hFFFF_FFFF;
   localparam logic          RST_REFLECT_BITS  = 1'b1;
   localparam crc_word_type  RST_FINAL_XOR     = 32'hFFFF_FFFF;

   // full-word bit reversal
   function automatic crc_word_type crc_bit_reverse(input crc_word_type value);
      crc_word_type result;
      for (int i = 0; i < CRC_WORD_WIDTH; i++) begin
         result[i] = value[CRC_WORD_WIDTH-1-i];
      end
      return result;
   endfunction

   // eight shift-and-xor steps on a left-aligned register and polynomial
   function automatic crc_word_type crc_byte_update(
      input crc_word_type aligned_reg,
      input crc_word_type aligned_poly,
      input logic [7:0]   data_byte,
      input logic         reflect
   );
      crc_word_type acc;
      logic         feedback;
      acc = aligned_reg;
      for (int i = 0; i < 8; i++) begin
         feedback = acc[CRC_WORD_WIDTH-1] ^ (reflect ? data_byte[i] : data_byte[7-i]);
         acc      = {acc[CRC_WORD_WIDTH-2:0], 1'b0} ^ (feedback ? aligned_poly : '0);
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

FILE: sv/configurable_crc_engine_core.sv
// A last byte's crc is registered and shows on the response port in the cycle after its acceptance.
// Throughput: one byte per cycle while req_stall is low; the kept crc register is
// updated by eight unrolled shift-and-xor steps computed combinationally.
// Requests stall only while a finished crc waits and the response side stalls.
// Reset (synchronous) loads the crc-32 settings and the initial value, and
// empties the response register.
// ----------------------------------------------------------------------------
// configurable_crc_engine_core: bytewise crc engine with run-time settings
// Width 4..32, polynomial, initial value, reflection and final xor are set
// through a write-only register port; one crc is returned per message.
// ----------------------------------------------------------------------------
`default_nettype none

module configurable_crc_engine_core
   import crc_eng_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // configuration writes
   input  wire logic                  csr_write_enable,
   input  wire csr_index_type         csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_write_data,
   // message bytes
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_data_byte,
   input  wire logic                  req_last_byte,
   // finished crc
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output crc_word_type               rsp_crc_value
);

   // settings and state
   crc_width_type width_ff;
   crc_word_type  poly_ff;
   crc_word_type  init_ff;
   logic          reflect_ff;
   crc_word_type  xor_ff;
   crc_word_type  crc_register_ff, crc_register_in;
   logic          rsp_valid_ff, rsp_valid_in;
   crc_word_type  rsp_crc_ff, rsp_crc_in;

   crc_width_type eff_width;
   crc_width_type shift_full;
   logic [SHIFT_BITS-1:0] shift_amt;
   crc_word_type  width_mask;
   crc_word_type  aligned_reg;
   crc_word_type  aligned_poly;
   crc_word_type  aligned_next;
   crc_word_type  finished_crc;
   logic          req_accept;
   logic          rsp_accept;

   // handshake
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_accept = rsp_valid_ff & ~rsp_stall;

   // effective width and left-alignment shift
   always_comb begin
      if (width_ff < crc_width_type'(CRC_MIN_WIDTH)) begin
         eff_width = crc_width_type'(CRC_MIN_WIDTH);
      end else if (width_ff > crc_width_type'(CRC_WIDTH_LIMIT)) begin
         eff_width = crc_width_type'(CRC_WIDTH_LIMIT);
      end else begin
         eff_width = width_ff;
      end
      shift_full = crc_width_type'(CRC_WORD_WIDTH) - eff_width;
      shift_amt  = shift_full[SHIFT_BITS-1:0];
      width_mask = {CRC_WORD_WIDTH{1'b1}} >> shift_amt;
   end

   // byte update on the left-aligned register
   always_comb begin
      aligned_reg  = crc_register_ff << shift_amt;
      aligned_poly = poly_ff << shift_amt;
      aligned_next = crc_byte_update(aligned_reg, aligned_poly, req_data_byte, reflect_ff);
      if (reflect_ff) begin
         finished_crc = crc_bit_reverse(aligned_next);
      end else begin
         finished_crc = aligned_next >> shift_amt;
      end
      finished_crc = (finished_crc ^ xor_ff) & width_mask;
   end

   // next state of the crc register
   always_comb begin
      crc_register_in = crc_register_ff;
      if (csr_write_enable && csr_index == CSR_INITIAL_VALUE) begin
         crc_register_in = csr_write_data;
      end else if (req_accept) begin
         crc_register_in = req_last_byte ? init_ff : (aligned_next >> shift_amt);
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_accept;
      rsp_crc_in   = rsp_crc_ff;
      if (req_accept && req_last_byte) begin
         rsp_valid_in = 1'b1;
         rsp_crc_in   = finished_crc;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= RST_CRC_WIDTH;
         poly_ff    <= RST_POLYNOMIAL;
         init_ff    <= RST_INITIAL_VALUE;
         reflect_ff <= RST_REFLECT_BITS;
         xor_ff     <= RST_FINAL_XOR;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CRC_WIDTH:     width_ff   <= csr_write_data[WIDTH_REG_BITS-1:0];
            CSR_POLYNOMIAL:    poly_ff    <= csr_write_data;
            CSR_INITIAL_VALUE: init_ff    <= csr_write_data;
            CSR_REFLECT_BITS:  reflect_ff <= csr_write_data[0];
            CSR_FINAL_XOR:     xor_ff     <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // crc state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_register_ff <= RST_INITIAL_VALUE;
         rsp_valid_ff    <= 1'b0;
      end else begin
         crc_register_ff <= crc_register_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_crc_ff <= rsp_crc_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_crc_value = rsp_crc_ff;

`ifndef SYNTHESIS
   // a last byte always leaves a finished crc behind
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_last_byte) |=> rsp_valid_ff)
      else $error("last byte accepted but no response pending");

   // a response only appears after a last byte
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_accept && req_last_byte))
      else $error("response raised without a last byte");

   // the register restarts from the initial value after each message
   a_reload_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_last_byte && !csr_write_enable)
      |=> crc_register_ff == $past(init_ff))
      else $error("crc register not reloaded after last byte");
`endif

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for configurable_crc_engine_core
// Streams byte messages through the engine under many crc settings (standard
// variants, random ones, out-of-range widths, mid-message writes) and checks
// every finished crc against a bytewise shift-and-xor predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import crc_eng_pkg::*;

   localparam csr_index_type FIRST_UNUSED_INDEX = csr_index_type'(CSR_FINAL_XOR + 1);
   localparam csr_index_type LAST_INDEX         = '1;
   localparam int            HOLD_CYCLES        = 150;
   localparam int            NORMAL_IDLE_PCT    = 26;

   typedef struct {
      logic [7:0] value;
      logic       is_last;
   } msg_byte_type;

   logic                      clock;
   logic                      reset            = 1'b1;
   logic                      csr_write_enable = 1'b0;
   csr_index_type             csr_index        = CSR_CRC_WIDTH;
   logic [CSR_DATA_WIDTH-1:0] csr_write_data   = '0;
   logic                      req_valid        = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_data_byte    = '0;
   logic                      req_last_byte    = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall        = 1'b0;
   crc_word_type              rsp_crc_value;

   // predictor copy of the settings and the running register
   crc_width_type cfg_width     = RST_CRC_WIDTH;
   crc_word_type  cfg_poly      = RST_POLYNOMIAL;
   crc_word_type  cfg_init      = RST_INITIAL_VALUE;
   logic          cfg_reflect   = RST_REFLECT_BITS;
   crc_word_type  cfg_final_xor = RST_FINAL_XOR;
   crc_word_type  crc_state     = RST_INITIAL_VALUE;

   msg_byte_type message_bytes[$];
   crc_word_type expected_crcs[$];
   msg_byte_type next_byte;
   int           bytes_submitted = 0;
   int           bytes_accepted  = 0;
   int           error_count     = 0;
   int           idle_pct        = NORMAL_IDLE_PCT;
   int           hold_requests   = 0;
   int           holds_taken     = 0;
   int           hold_left       = 0;

   configurable_crc_engine_core DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_crc_value    (rsp_crc_value)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic flag_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   // run one byte through the predicted crc register, queue the crc on a last byte
   task automatic absorb_byte(input logic [7:0] data, input logic last);
      int           w;
      crc_word_type mask;
      crc_word_type poly;
      crc_word_type acc;
      crc_word_type mirrored;
      logic         top;
      w = cfg_width;
      if (w < CRC_MIN_WIDTH) w = CRC_MIN_WIDTH;
      if (w > CRC_WIDTH_LIMIT) w = CRC_WIDTH_LIMIT;
      mask = (w >= CRC_WORD_WIDTH) ? '1 : ((crc_word_type'(1) << w) - 1);
      poly = cfg_poly & mask;
      acc  = crc_state & mask;
      for (int i = 0; i < 8; i++) begin
         top = acc[w-1] ^ (cfg_reflect ? data[i] : data[7-i]);
         acc = (acc << 1) & mask;
         if (top) acc = acc ^ poly;
      end
      if (!last) begin
         crc_state = acc;
      end else begin
         if (cfg_reflect) begin
            mirrored = '0;
            for (int i = 0; i < w; i++) mirrored[w-1-i] = acc[i];
            acc = mirrored;
         end
         expected_crcs.push_back((acc ^ cfg_final_xor) & mask);
         crc_state = cfg_init;
      end
   endtask

   // one register write per clock; the caller lowers the enable afterwards
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      case (idx)
         CSR_CRC_WIDTH:     cfg_width = value[WIDTH_REG_BITS-1:0];
         CSR_POLYNOMIAL:    cfg_poly = value;
         CSR_INITIAL_VALUE: begin
            cfg_init  = value;
            crc_state = value;
         end
         CSR_REFLECT_BITS:  cfg_reflect = value[0];
         CSR_FINAL_XOR:     cfg_final_xor = value;
         default: ;
      endcase
   endtask

   task automatic end_csr_writes();
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic write_setting(input int w, input crc_word_type poly, input crc_word_type init,
                                input logic refl, input crc_word_type xor_value);
      write_csr(CSR_CRC_WIDTH, ($urandom & ~32'h3F) | w);
      write_csr(CSR_POLYNOMIAL, poly);
      write_csr(CSR_INITIAL_VALUE, init);
      write_csr(CSR_REFLECT_BITS, ($urandom & ~32'h1) | refl);
      write_csr(CSR_FINAL_XOR, xor_value);
      end_csr_writes();
   endtask

   // standard variants
   task automatic write_preset(input int k);
      case (k)
         0:  write_setting(16, 32'h1021, 32'hFFFF, 1'b0, 32'h0);
         1:  write_setting(16, 32'h8005, 32'h0, 1'b1, 32'h0);
         2:  write_setting(32, 32'h04C11DB7, 32'hFFFFFFFF, 1'b0, 32'h0);
         3:  write_setting(16, 32'h3D65, 32'h0, 1'b1, 32'hFFFF);
         4:  write_setting(8, 32'h31, 32'h0, 1'b1, 32'h0);
         5:  write_setting(8, 32'h07, 32'h0, 1'b0, 32'h0);
         6:  write_setting(5, 32'h15, 32'h1F, 1'b1, 32'h1F);
         7:  write_setting(7, 32'h09, 32'h0, 1'b0, 32'h0);
         8:  write_setting(4, 32'h03, 32'h0, 1'b1, 32'h0);
         9:  write_setting(8, 32'h55, 32'h0, 1'b0, 32'h55);
         default: write_setting(32, 32'h04C11DB7, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF);
      endcase
   endtask

   // random setting: any width code, full-word values, some registers left alone
   task automatic write_random_setting();
      int w;
      case ($urandom_range(7))
         0:       w = ($urandom_range(1) == 0) ? $urandom_range(3) : $urandom_range(33, 63);
         1:       w = ($urandom_range(1) == 0) ? CRC_MIN_WIDTH : CRC_MAX_WIDTH;
         default: w = $urandom_range(CRC_MIN_WIDTH, CRC_MAX_WIDTH);
      endcase
      if ($urandom_range(4) == 0) begin
         write_csr(csr_index_type'($urandom_range(FIRST_UNUSED_INDEX, LAST_INDEX)), $urandom);
      end
      if ($urandom_range(3) != 0) write_csr(CSR_CRC_WIDTH, ($urandom & ~32'h3F) | w);
      if ($urandom_range(3) != 0) write_csr(CSR_POLYNOMIAL, $urandom);
      if ($urandom_range(3) != 0) write_csr(CSR_INITIAL_VALUE, $urandom);
      if ($urandom_range(3) != 0) write_csr(CSR_REFLECT_BITS, $urandom);
      if ($urandom_range(3) != 0) write_csr(CSR_FINAL_XOR, $urandom);
      end_csr_writes();
   endtask

   task automatic queue_byte(input logic [7:0] value, input logic is_last);
      msg_byte_type b;
      b.value   = value;
      b.is_last = is_last;
      message_bytes.push_back(b);
      bytes_submitted++;
   endtask

   // random messages; the final one may be cut short and left open
   task automatic queue_messages(input int count);
      int sent;
      int len;
      sent = 0;
      while (sent < count) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         for (int j = 0; j < len && sent < count; j++) begin
            queue_byte(8'($urandom), j == len - 1);
            sent++;
         end
      end
   endtask

   // wait until every request is taken and every crc has come back
   task automatic wait_for_idle();
      while (bytes_accepted != bytes_submitted || expected_crcs.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_byte(req_data_byte, req_last_byte);
            bytes_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (message_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
               next_byte = message_bytes.pop_front();
               req_valid     <= 1'b1;
               req_data_byte <= next_byte.value;
               req_last_byte <= next_byte.is_last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // crc monitor and response stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_crcs.size() == 0) begin
               flag_error($sformatf("crc_value %h with no message end pending", rsp_crc_value));
            end else if (rsp_crc_value !== expected_crcs[0]) begin
               flag_error($sformatf("crc_value got %h expected %h", rsp_crc_value,
                                    expected_crcs.pop_front()));
            end else begin
               void'(expected_crcs.pop_front());
            end
         end
         if (hold_requests != holds_taken) begin
            holds_taken++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < idle_pct);
         end
      end
   end

   // stimulus
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: check string and extreme bytes
      for (int i = 0; i < 9; i++) queue_byte(8'(8'h31 + i), i == 8);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b1);
      wait_for_idle();

      // width below range, all-ones values, msb first; leave a message open
      write_setting(0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'hFFFFFFFF);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'h12, 1'b0);
      queue_byte(8'h34, 1'b0);
      queue_byte(8'h56, 1'b0);
      wait_for_idle();

      // polynomial change in the middle of a message
      write_csr(CSR_POLYNOMIAL, 32'h1021);
      end_csr_writes();
      queue_byte(8'h80, 1'b0);
      queue_byte(8'h01, 1'b1);
      queue_byte(8'hA5, 1'b0);
      queue_byte(8'h5A, 1'b0);
      wait_for_idle();

      // width above range, ignored indexes, initial value restarting the open message
      write_csr(CSR_CRC_WIDTH, 32'hFFFF_FFFF);
      write_csr(FIRST_UNUSED_INDEX, 32'h0);
      write_csr(LAST_INDEX, 32'hFFFF_FFFF);
      write_csr(CSR_INITIAL_VALUE, 32'h0);
      write_csr(CSR_REFLECT_BITS, 32'h1);
      write_csr(CSR_FINAL_XOR, 32'h0);
      end_csr_writes();
      queue_byte(8'h7E, 1'b0);
      queue_byte(8'hC3, 1'b0);
      queue_byte(8'h00, 1'b1);
      wait_for_idle();

      // random phases: presets and random settings
      for (int p = 0; p < 21; p++) begin
         idle_pct = (p == 7) ? 0 : NORMAL_IDLE_PCT;
         if (p < 11) write_preset(p);
         else write_random_setting();
         if (p == 13 || p == 18) hold_requests++;
         queue_messages(50);
         wait_for_idle();
      end

      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
sv/crc_eng_pkg.sv
sv/configurable_crc_engine_core.sv
tb/testbench.sv
